>>> hdl/vrd_pkg.sv
package vrd_pkg;

    // Widths of the internal counters.
    localparam int TOTAL_W = 27;
    localparam int LEN_W   = 14;

    // Field sizes of the message layout, in octets.
    localparam int HEADER_DIGITS  = 8;
    localparam int NAMELEN_DIGITS = 2;
    localparam int VALLEN_DIGITS  = 4;

    // Octets that may open a variable name.
    localparam logic [7:0] NAME_MARK_DOLLAR = 8'h24;
    localparam logic [7:0] NAME_MARK_HASH   = 8'h23;

    // Result kinds.
    localparam logic [2:0] KIND_NAME        = 3'd0;
    localparam logic [2:0] KIND_VALUE       = 3'd1;
    localparam logic [2:0] KIND_EMPTY_VALUE = 3'd2;
    localparam logic [2:0] KIND_BAD_NAME    = 3'd3;
    localparam logic [2:0] KIND_EMPTY_MSG   = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_MARKER  = 3'd1,
        PH_NAMELEN = 3'd2,
        PH_NAME    = 3'd3,
        PH_TYPE    = 3'd4,
        PH_VALLEN  = 3'd5,
        PH_VALUE   = 3'd6,
        PH_IDLE    = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] stream_octet;
        logic       message_start;
    } in_word_t;

    typedef struct packed {
        logic [7:0] octet_out;
        logic [2:0] item_kind;
        logic       end_of_name;
        logic       end_of_record;
        logic       end_of_message;
    } out_word_t;

    // True for an ASCII decimal digit.
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

>>> hdl/vrd_stream_if.sv
interface vrd_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/variable_record_deframer_core.sv
// Deframer for serialized variable messages. One input word carries one message octet
// and a start flag; the core accepts one word per clock and returns at most one result
// word per input word through a two-entry output buffer, so a stalled consumer halts
// the input only once both entries hold results. Each result is a name octet, a value
// octet, an empty-value mark, a bad-name error or an empty-message mark, with flags
// for the end of a name, a record and the message. The rate of one word per cycle,
// while the buffer has room, rests on the combinational phase and counter update,
// whose longest path is the times-ten accumulate of the 27-bit header total. After a
// bad name or a message end, octets are dropped until a word with the start flag set.
module variable_record_deframer_core (
    input  logic         clk,
    input  logic         rst_n,
    vrd_stream_if.sink   in_words,
    vrd_stream_if.source out_words
);
    import vrd_pkg::*;

    // Parser state.
    phase_t             phase_reg, phase_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] offset_reg, offset_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic [LEN_W-1:0]   accum_reg, accum_next;
    logic               stopped_reg, stopped_next;

    // Output buffer: main entry drives the port, skid entry catches one more result.
    logic      main_valid_reg, main_valid_next;
    out_word_t main_data_reg, main_data_next;
    logic      skid_valid_reg, skid_valid_next;
    out_word_t skid_data_reg, skid_data_next;

    // State seen by this word, after a message start has been applied.
    phase_t             phase_cur;
    logic [TOTAL_W-1:0] total_cur;
    logic [TOTAL_W-1:0] offset_cur;
    logic [LEN_W-1:0]   remain_cur;
    logic [LEN_W-1:0]   accum_cur;
    logic               stopped_cur;

    logic [7:0] octet;
    logic       digit_ok;
    logic [3:0] digit_val;
    logic       res_valid;
    out_word_t  res;
    logic       in_accept;
    logic       out_pop;
    logic       push;

    assign octet     = in_words.data.stream_octet;
    assign digit_val = octet[3:0];
    assign in_words.ready = ~skid_valid_reg;
    assign in_accept = in_words.valid & in_words.ready;
    assign out_pop   = main_valid_reg & out_words.ready;
    assign push      = in_accept & res_valid;

    assign out_words.valid = main_valid_reg;
    assign out_words.data  = main_data_reg;

    // Message start restarts the parser before the octet is parsed.
    always_comb
    begin
        if (in_words.data.message_start)
        begin
            phase_cur   = PH_HEADER;
            total_cur   = '0;
            offset_cur  = '0;
            remain_cur  = '0;
            accum_cur   = '0;
            stopped_cur = 1'b0;
        end
        else
        begin
            phase_cur   = phase_reg;
            total_cur   = total_reg;
            offset_cur  = offset_reg;
            remain_cur  = remain_reg;
            accum_cur   = accum_reg;
            stopped_cur = stopped_reg;
        end
    end

    // Phase step for one octet.
    always_comb
    begin
        phase_next   = phase_cur;
        total_next   = total_cur;
        offset_next  = offset_cur;
        remain_next  = remain_cur;
        accum_next   = accum_cur;
        stopped_next = stopped_cur;
        res_valid    = 1'b0;
        res          = '0;
        digit_ok     = ~stopped_cur & is_digit(octet);

        if (phase_cur != PH_IDLE)
        begin
            offset_next = offset_cur + TOTAL_W'(1);
            if (remain_cur != '0)
            begin
                remain_next = remain_cur - LEN_W'(1);
            end

            unique case (phase_cur)
                PH_HEADER:
                begin
                    if (digit_ok)
                    begin
                        total_next = (total_cur << 3) + (total_cur << 1)
                                   + TOTAL_W'(digit_val);
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                    if (offset_next >= TOTAL_W'(HEADER_DIGITS))
                    begin
                        if (offset_next < total_next)
                        begin
                            phase_next = PH_MARKER;
                        end
                        else
                        begin
                            res_valid          = 1'b1;
                            res.item_kind      = KIND_EMPTY_MSG;
                            res.end_of_message = 1'b1;
                            phase_next         = PH_IDLE;
                        end
                    end
                end
                PH_MARKER:
                begin
                    phase_next   = PH_NAMELEN;
                    remain_next  = LEN_W'(NAMELEN_DIGITS);
                    accum_next   = '0;
                    stopped_next = 1'b0;
                end
                PH_NAMELEN:
                begin
                    if (digit_ok)
                    begin
                        accum_next = (accum_cur << 3) + (accum_cur << 1)
                                   + LEN_W'(digit_val);
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                    if (remain_next == '0)
                    begin
                        if (accum_next == '0)
                        begin
                            res_valid     = 1'b1;
                            res.item_kind = KIND_BAD_NAME;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            phase_next  = PH_NAME;
                            remain_next = accum_next;
                        end
                    end
                end
                PH_NAME:
                begin
                    // The first name octet must be one of the two name marks.
                    if (({1'b0, remain_next} + (LEN_W+1)'(1)) == {1'b0, accum_cur}
                        && octet != NAME_MARK_DOLLAR && octet != NAME_MARK_HASH)
                    begin
                        res_valid     = 1'b1;
                        res.item_kind = KIND_BAD_NAME;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        res_valid     = 1'b1;
                        res.octet_out = octet;
                        res.item_kind = KIND_NAME;
                        if (remain_next == '0)
                        begin
                            res.end_of_name = 1'b1;
                            phase_next      = PH_TYPE;
                        end
                    end
                end
                PH_TYPE:
                begin
                    phase_next   = PH_VALLEN;
                    remain_next  = LEN_W'(VALLEN_DIGITS);
                    accum_next   = '0;
                    stopped_next = 1'b0;
                end
                PH_VALLEN:
                begin
                    if (digit_ok)
                    begin
                        accum_next = (accum_cur << 3) + (accum_cur << 1)
                                   + LEN_W'(digit_val);
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                    if (remain_next == '0)
                    begin
                        if (accum_next == '0)
                        begin
                            res_valid         = 1'b1;
                            res.item_kind     = KIND_EMPTY_VALUE;
                            res.end_of_record = 1'b1;
                            if (offset_next >= total_cur)
                            begin
                                res.end_of_message = 1'b1;
                                phase_next         = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_MARKER;
                            end
                        end
                        else
                        begin
                            phase_next  = PH_VALUE;
                            remain_next = accum_next;
                        end
                    end
                end
                PH_VALUE:
                begin
                    res_valid     = 1'b1;
                    res.octet_out = octet;
                    res.item_kind = KIND_VALUE;
                    if (remain_next == '0)
                    begin
                        res.end_of_record = 1'b1;
                        if (offset_next >= total_cur)
                        begin
                            res.end_of_message = 1'b1;
                            phase_next         = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_MARKER;
                        end
                    end
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Output buffer update.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            // Input is held off; the skid entry moves up when the main one drains.
            if (out_pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !out_pop)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
            else
            begin
                main_valid_next = 1'b1;
                main_data_next  = res;
            end
        end
        else if (out_pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    // Control and parser registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            total_reg      <= '0;
            offset_reg     <= '0;
            remain_reg     <= '0;
            accum_reg      <= '0;
            stopped_reg    <= 1'b0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg   <= phase_next;
                total_reg   <= total_next;
                offset_reg  <= offset_next;
                remain_reg  <= remain_next;
                accum_reg   <= accum_next;
                stopped_reg <= stopped_next;
            end
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> dv/tb_variable_record_deframer_core.sv
module tb_variable_record_deframer_core;
    import vrd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic clk;
    logic rst_n;

    vrd_stream_if #(.payload_t(in_word_t))  in_ch ();
    vrd_stream_if #(.payload_t(out_word_t)) out_ch ();

    variable_record_deframer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_words  (in_ch),
        .out_words (out_ch)
    );

    // Expected result words, oldest first.
    out_word_t expected_words[$];

    // Octets of the message being built for sending.
    logic [7:0] frame_octets[$];

    // Parser state as the testbench predicts it.
    phase_t      dfr_phase;
    logic [26:0] dfr_total;
    logic [26:0] dfr_offset;
    logic [13:0] dfr_remaining;
    logic [13:0] dfr_length;
    logic        dfr_stopped;

    int  parsed_octets;
    int  mismatches;
    int  cycle_count;
    bit  sender_gaps;
    bit  receiver_gaps;
    int  receiver_hold;
    int  hold_left;
    int  stall_left;
    out_word_t want;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Digits accumulate until the first non-digit of the field; later octets are ignored.
    function automatic logic [26:0] accumulate_digit(input logic [26:0] acc,
                                                     input logic [7:0] c);
        if (!dfr_stopped && c >= 8'h30 && c <= 8'h39)
            return acc * 27'd10 + {19'd0, c - 8'h30};
        dfr_stopped = 1'b1;
        return acc;
    endfunction

    task automatic open_field(input phase_t next_phase, input logic [13:0] digits);
        dfr_phase     = next_phase;
        dfr_remaining = digits;
        dfr_length    = '0;
        dfr_stopped   = 1'b0;
    endtask

    // A completed record either ends the message or waits for the next marker.
    function automatic logic close_record();
        if (dfr_offset >= dfr_total)
        begin
            dfr_phase = PH_IDLE;
            return 1'b1;
        end
        dfr_phase = PH_MARKER;
        return 1'b0;
    endfunction

    // Advance the predicted parser by one octet and give the result word, if any.
    task automatic deframe_octet(input logic [7:0] c, input logic start,
                                 output logic produced, output out_word_t res);
        logic [26:0] acc;
        produced = 1'b0;
        res = '0;
        if (start)
        begin
            dfr_phase     = PH_HEADER;
            dfr_total     = '0;
            dfr_offset    = '0;
            dfr_remaining = '0;
            dfr_length    = '0;
            dfr_stopped   = 1'b0;
        end
        if (dfr_phase == PH_IDLE)
            return;
        parsed_octets++;
        dfr_offset = dfr_offset + 27'd1;
        if (dfr_remaining != '0)
            dfr_remaining = dfr_remaining - 14'd1;
        case (dfr_phase)
            PH_HEADER:
            begin
                dfr_total = accumulate_digit(dfr_total, c);
                if (dfr_offset >= HEADER_DIGITS)
                begin
                    if (dfr_offset < dfr_total)
                        dfr_phase = PH_MARKER;
                    else
                    begin
                        res.item_kind      = KIND_EMPTY_MSG;
                        res.end_of_message = 1'b1;
                        produced           = 1'b1;
                        dfr_phase          = PH_IDLE;
                    end
                end
            end
            PH_MARKER:
                open_field(PH_NAMELEN, LEN_W'(NAMELEN_DIGITS));
            PH_NAMELEN:
            begin
                acc = accumulate_digit({13'd0, dfr_length}, c);
                dfr_length = acc[13:0];
                if (dfr_remaining == '0)
                begin
                    if (dfr_length == '0)
                    begin
                        res.item_kind = KIND_BAD_NAME;
                        produced      = 1'b1;
                        dfr_phase     = PH_IDLE;
                    end
                    else
                    begin
                        dfr_phase     = PH_NAME;
                        dfr_remaining = dfr_length;
                    end
                end
            end
            PH_NAME:
            begin
                // The first name octet must be one of the two name marks.
                if (({1'b0, dfr_remaining} + 15'd1 == {1'b0, dfr_length})
                    && c != NAME_MARK_DOLLAR && c != NAME_MARK_HASH)
                begin
                    res.item_kind = KIND_BAD_NAME;
                    produced      = 1'b1;
                    dfr_phase     = PH_IDLE;
                end
                else
                begin
                    res.octet_out = c;
                    res.item_kind = KIND_NAME;
                    produced      = 1'b1;
                    if (dfr_remaining == '0)
                    begin
                        res.end_of_name = 1'b1;
                        dfr_phase       = PH_TYPE;
                    end
                end
            end
            PH_TYPE:
                open_field(PH_VALLEN, LEN_W'(VALLEN_DIGITS));
            PH_VALLEN:
            begin
                acc = accumulate_digit({13'd0, dfr_length}, c);
                dfr_length = acc[13:0];
                if (dfr_remaining == '0)
                begin
                    if (dfr_length == '0)
                    begin
                        res.item_kind      = KIND_EMPTY_VALUE;
                        res.end_of_record  = 1'b1;
                        res.end_of_message = close_record();
                        produced           = 1'b1;
                    end
                    else
                    begin
                        dfr_phase     = PH_VALUE;
                        dfr_remaining = dfr_length;
                    end
                end
            end
            PH_VALUE:
            begin
                res.octet_out = c;
                res.item_kind = KIND_VALUE;
                produced      = 1'b1;
                if (dfr_remaining == '0)
                begin
                    res.end_of_record  = 1'b1;
                    res.end_of_message = close_record();
                end
            end
            default:
                dfr_phase = PH_IDLE;
        endcase
    endtask

    // Offer one word and wait until the block takes it.
    task send_octet(input logic [7:0] octet, input logic start);
        logic      produced;
        out_word_t res;
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {octet, start};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        deframe_octet(octet, start, produced, res);
        if (produced)
            expected_words.push_back(res);
    endtask

    task send_string(input string s, input logic first_start);
        int i;
        for (i = 0; i < s.len(); i++)
            send_octet(s[i], first_start && i == 0);
    endtask

    task send_frame();
        int i;
        for (i = 0; i < frame_octets.size(); i++)
            send_octet(frame_octets[i], i == 0);
    endtask

    // Lower valid and wait until every expected word has come back.
    task wait_for_drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0);
    endtask

    task push_decimal(input int value, input int digits);
        int divisor;
        int i;
        divisor = 1;
        repeat (digits - 1) divisor *= 10;
        for (i = 0; i < digits; i++)
        begin
            frame_octets.push_back(8'h30 + 8'((value / divisor) % 10));
            divisor /= 10;
        end
    endtask

    // Length field that now and then carries a stray octet in place of a digit.
    task push_length_field(input int value, input int digits);
        push_decimal(value, digits);
        if ($urandom_range(0, 11) == 0)
            frame_octets[frame_octets.size() - 1 - $urandom_range(0, digits - 1)] =
                8'($urandom_range(0, 255));
    endtask

    // Write the total into the eight header places at the front of the frame.
    task set_header(input int total);
        int t;
        int i;
        t = total;
        for (i = HEADER_DIGITS - 1; i >= 0; i--)
        begin
            frame_octets[i] = 8'h30 + 8'(t % 10);
            t = t / 10;
        end
    endtask

    function automatic logic [7:0] name_mark();
        return $urandom_range(0, 1) ? NAME_MARK_DOLLAR : NAME_MARK_HASH;
    endfunction

    // One record, well formed, with random content.
    task build_clean_frame(input int name_len, input int value_len);
        int i;
        frame_octets.delete();
        repeat (HEADER_DIGITS) frame_octets.push_back(8'h30);
        frame_octets.push_back(8'($urandom_range(0, 255)));
        push_decimal(name_len, NAMELEN_DIGITS);
        for (i = 0; i < name_len; i++)
            frame_octets.push_back(i == 0 ? name_mark() : 8'($urandom_range(0, 255)));
        frame_octets.push_back(8'($urandom_range(0, 255)));
        push_decimal(value_len, VALLEN_DIGITS);
        repeat (value_len) frame_octets.push_back(8'($urandom_range(0, 255)));
        set_header(frame_octets.size());
    endtask

    // Mostly well-formed messages, with broken headers, lengths, names and cut frames mixed in.
    task build_random_frame();
        int n_records;
        int name_len;
        int value_len;
        int total_len;
        int pick;
        int r;
        int i;
        int cut;
        frame_octets.delete();
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            repeat ($urandom_range(1, 16)) frame_octets.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat (HEADER_DIGITS) frame_octets.push_back(8'h30);
        n_records = $urandom_range(0, 4);
        for (r = 0; r < n_records; r++)
        begin
            frame_octets.push_back(8'($urandom_range(0, 255)));
            name_len = ($urandom_range(0, 39) == 0) ? 99 : $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0)
                name_len = 0;
            push_length_field(name_len, NAMELEN_DIGITS);
            for (i = 0; i < name_len; i++)
            begin
                if (i == 0 && $urandom_range(0, 14) != 0)
                    frame_octets.push_back(name_mark());
                else
                    frame_octets.push_back(8'($urandom_range(0, 255)));
            end
            frame_octets.push_back(8'($urandom_range(0, 255)));
            // The largest value length, cut short by the next message start.
            if ($urandom_range(0, 29) == 0)
            begin
                push_decimal(9999, VALLEN_DIGITS);
                repeat ($urandom_range(0, 5)) frame_octets.push_back(8'($urandom_range(0, 255)));
                break;
            end
            pick = $urandom_range(0, 9);
            if (pick < 2)
                value_len = 0;
            else if (pick < 9)
                value_len = $urandom_range(1, 8);
            else
                value_len = $urandom_range(9, 40);
            push_length_field(value_len, VALLEN_DIGITS);
            repeat (value_len) frame_octets.push_back(8'($urandom_range(0, 255)));
        end
        total_len = frame_octets.size();
        pick = $urandom_range(0, 99);
        if (pick < 8)
            total_len = $urandom_range(0, HEADER_DIGITS);
        else if (pick < 16)
            total_len = $urandom_range(HEADER_DIGITS + 1, total_len);
        else if (pick < 21)
            total_len = 99999999;
        else if (pick < 25)
            total_len = total_len + $urandom_range(1, 50);
        set_header(total_len);
        if (pick >= 25 && pick < 30)
            frame_octets[$urandom_range(0, HEADER_DIGITS - 1)] = 8'($urandom_range(0, 255));
        // Trailing octets that the parser should drop, or a frame cut off early.
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 6)) frame_octets.push_back(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, frame_octets.size());
            while (frame_octets.size() > cut)
                void'(frame_octets.pop_back());
        end
    endtask

    // Octets before any message start parse as a header from the reset state.
    task test_octets_before_first_start();
        send_string("12", 1'b0);
    endtask

    // A header total of eight gives the empty-message word.
    task test_empty_message();
        send_string("00000008", 1'b1);
    endtask

    // A one-octet name, an empty value, then a record with a zero name length.
    task test_empty_value_and_zero_name();
        send_string("00000099", 1'b1);
        send_octet(8'hFF, 1'b0);
        send_string("01", 1'b0);
        send_octet(NAME_MARK_DOLLAR, 1'b0);
        send_octet(8'h00, 1'b0);
        send_string("0000", 1'b0);
        send_octet(8'hFF, 1'b0);
        send_string("00", 1'b0);
        send_octet(8'hFF, 1'b0);
    endtask

    // A name whose first octet is not a name mark.
    task test_bad_first_name_octet();
        send_string("00000099", 1'b1);
        send_octet(8'h00, 1'b0);
        send_string("01A", 1'b0);
    endtask

    task test_random_messages(input int count);
        int target;
        target = parsed_octets + count;
        while (parsed_octets < target)
        begin
            build_random_frame();
            send_frame();
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the block stalls its input.
    task test_output_stall_fills_buffer();
        sender_gaps = 1'b0;
        build_clean_frame(4, 60);
        receiver_hold = 80;
        send_frame();
        sender_gaps = 1'b1;
    endtask

    // The sender pauses until every result has come, then goes on.
    task test_pause_until_drained();
        build_clean_frame(3, 5);
        send_frame();
        wait_for_drain();
        build_clean_frame(1, 0);
        send_frame();
    endtask

    // Receiver ready, with random stall bursts and an occasional long hold-off.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (receiver_hold > 0)
            begin
                hold_left     = receiver_hold;
                receiver_hold = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (receiver_gaps && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task compare_field(input string field, input logic [7:0] exp_val, input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, out_ch.data);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                compare_field("octet_out", want.octet_out, out_ch.data.octet_out);
                compare_field("item_kind", 8'(want.item_kind), 8'(out_ch.data.item_kind));
                compare_field("end_of_name", 8'(want.end_of_name),
                              8'(out_ch.data.end_of_name));
                compare_field("end_of_record", 8'(want.end_of_record),
                              8'(out_ch.data.end_of_record));
                compare_field("end_of_message", 8'(want.end_of_message),
                              8'(out_ch.data.end_of_message));
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.data    <= '0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        receiver_hold = 0;
        hold_left     = 0;
        stall_left    = 0;
        mismatches    = 0;
        cycle_count   = 0;
        parsed_octets = 0;
        dfr_phase     = PH_HEADER;
        dfr_total     = '0;
        dfr_offset    = '0;
        dfr_remaining = '0;
        dfr_length    = '0;
        dfr_stopped   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_octets_before_first_start();
        test_empty_message();
        test_empty_value_and_zero_name();
        test_bad_first_name_octet();
        test_random_messages(500);
        test_output_stall_fills_buffer();
        test_pause_until_drained();
        test_random_messages(100);

        // Last part runs with no idling on either side.
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        test_random_messages(200);

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/vrd_pkg.sv
hdl/vrd_stream_if.sv
hdl/variable_record_deframer_core.sv
dv/tb_variable_record_deframer_core.sv
